// ===== rtl/core/tpu_pkg.sv =====
package tpu_pkg;

  localparam int CntW    = 14;
  localparam int ByteW   = 8;
  localparam int QDepth  = 4;
  localparam int QPtrW   = $clog2(QDepth);
  localparam int QCntW   = $clog2(QDepth + 1);

  localparam logic [ByteW-1:0] MaskFlag   = 8'h80;
  localparam logic [4:0]       FullMask   = 5'h1F;
  localparam logic [ByteW-1:0] ExtEffect  = 8'h0E;
  localparam logic [ByteW-1:0] ExtBase    = 8'd36;
  localparam logic [ByteW-1:0] NibbleMask = 8'h0F;
  localparam logic [2:0]       NoField    = 3'd5;
  localparam logic [2:0]       ParamField = 3'd4;

  typedef struct packed {
    logic             fresh;
    logic             store;
    logic             finish;
    logic             use_param;
    logic [1:0]       idx;
    logic [ByteW-1:0] data;
    logic             last;
  } op_t;

  function automatic logic [2:0] next_present(input logic [4:0] mask, input logic [2:0] from);
    logic [2:0] res;
    res = NoField;
    for (int j = 4; j >= 0; j--) begin
      if ((3'(j) >= from) && mask[j]) begin
        res = 3'(j);
      end
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/tpu_front.sv =====
module tpu_front #(
  parameter int MAX_CELLS = 8192
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  logic [tpu_pkg::ByteW-1:0] stream_byte,
  input  logic                      pattern_start,
  input  logic [tpu_pkg::CntW-1:0]  cells_in_pattern,
  output logic                      push,
  output tpu_pkg::op_t              op
);
  import tpu_pkg::*;

  localparam int LimW = 17;
  localparam logic [LimW-1:0] Limit = LimW'(MAX_CELLS);

  logic [CntW-1:0] cells_left, cells_left_next;
  logic            in_cell, in_cell_next;
  logic [4:0]      field_mask, field_mask_next;
  logic [2:0]      field_index, field_index_next;

  logic [CntW-1:0] cl;
  logic            ic;
  logic [4:0]      fm;
  logic [2:0]      fi;
  logic [2:0]      nf;
  logic            fresh;
  logic [LimW-1:0] n_ext;

  always_comb begin
    n_ext = {{(LimW-CntW){1'b0}}, cells_in_pattern};
    if (pattern_start) begin
      cl = (n_ext > Limit) ? Limit[CntW-1:0] : cells_in_pattern;
      ic = 1'b0;
      fm = '0;
      fi = '0;
    end else begin
      cl = cells_left;
      ic = in_cell;
      fm = field_mask;
      fi = field_index;
    end

    cells_left_next  = cl;
    in_cell_next     = ic;
    field_mask_next  = fm;
    field_index_next = fi;
    push             = 1'b0;
    fresh            = 1'b0;
    nf               = NoField;
    op               = '0;
    op.data          = stream_byte;
    op.last          = (cl == CntW'(1));

    if (accept && (cl != '0)) begin
      push = 1'b1;
      if (!ic) begin
        fresh    = 1'b1;
        op.fresh = 1'b1;
        if ((stream_byte & MaskFlag) != '0) begin
          field_mask_next = stream_byte[4:0];
          nf = next_present(stream_byte[4:0], 3'd0);
          if (nf == NoField) begin
            op.finish       = 1'b1;
            cells_left_next = cl - CntW'(1);
            in_cell_next    = 1'b0;
            field_mask_next = '0;
            field_index_next = '0;
          end else begin
            in_cell_next     = 1'b1;
            field_index_next = nf;
          end
        end else begin
          fm = FullMask;
          fi = '0;
        end
      end
      if (ic || ((stream_byte & MaskFlag) == '0)) begin
        op.fresh = fresh;
        if (fi >= ParamField) begin
          op.finish        = 1'b1;
          op.use_param     = 1'b1;
          cells_left_next  = cl - CntW'(1);
          in_cell_next     = 1'b0;
          field_mask_next  = '0;
          field_index_next = '0;
        end else begin
          op.store = 1'b1;
          op.idx   = fi[1:0];
          nf = next_present(fm, fi + 3'd1);
          if (nf == NoField) begin
            op.finish        = 1'b1;
            cells_left_next  = cl - CntW'(1);
            in_cell_next     = 1'b0;
            field_mask_next  = '0;
            field_index_next = '0;
          end else begin
            in_cell_next     = 1'b1;
            field_mask_next  = fm;
            field_index_next = nf;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cells_left  <= '0;
      in_cell     <= 1'b0;
      field_mask  <= '0;
      field_index <= '0;
    end else if (accept) begin
      cells_left  <= cells_left_next;
      in_cell     <= in_cell_next;
      field_mask  <= field_mask_next;
      field_index <= field_index_next;
    end
  end

endmodule

// ===== rtl/core/tpu_queue.sv =====
module tpu_queue (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  tpu_pkg::op_t push_op,
  output logic         push_ready,
  input  logic         pop,
  output logic         head_valid,
  output tpu_pkg::op_t head_op
);
  import tpu_pkg::*;

  op_t              mem [QDepth];
  logic [QPtrW-1:0] wr_ptr;
  logic [QPtrW-1:0] rd_ptr;
  logic [QCntW-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign push_ready = (count != QCntW'(QDepth));
  assign head_valid = (count != '0);
  assign head_op    = mem[rd_ptr];
  assign do_wr      = push && push_ready;
  assign do_rd      = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + QPtrW'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + QPtrW'(1);
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + QCntW'(1);
        2'b01:   count <= count - QCntW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/core/tpu_back.sv =====
module tpu_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      head_valid,
  input  tpu_pkg::op_t              head_op,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [tpu_pkg::ByteW-1:0] note,
  output logic [tpu_pkg::ByteW-1:0] instrument,
  output logic [tpu_pkg::ByteW-1:0] volume_column,
  output logic [tpu_pkg::ByteW-1:0] effect_command,
  output logic [tpu_pkg::ByteW-1:0] effect_parameter,
  output logic                      last_cell
);
  import tpu_pkg::*;

  logic [ByteW-1:0] partial [4];
  logic [ByteW-1:0] base [4];
  logic [ByteW-1:0] eff;
  logic [ByteW-1:0] param;

  assign pop = head_valid && (!head_op.finish || !out_valid || out_ready);

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      base[k] = head_op.fresh ? '0 : partial[k];
    end
    if (head_op.store) begin
      base[head_op.idx] = head_op.data;
    end
    eff   = base[3];
    param = head_op.use_param ? head_op.data : '0;
    if (eff == ExtEffect) begin
      eff   = ExtBase + {4'b0, param[7:4]};
      param = param & NibbleMask;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 4; k++) begin
        partial[k] <= '0;
      end
    end else if (pop) begin
      for (int k = 0; k < 4; k++) begin
        partial[k] <= head_op.finish ? '0 : base[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && head_op.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head_op.finish) begin
      note             <= base[0];
      instrument       <= base[1];
      volume_column    <= base[2];
      effect_command   <= eff;
      effect_parameter <= param;
      last_cell        <= head_op.last;
    end
  end

endmodule

// ===== rtl/core/tracker_pattern_unpacker_top.sv =====
// a cell is written into the queue with the byte that completes it, then registered onto the outputs
// throughput: one byte per cycle while the queue is not full, set by the front decoder's per-byte state update
// a four-item queue lets the decoder run on while a finished cell waits on out_ready
// reset: synchronous, clears cell state, cell count, queue and out_valid
// after reset bytes are dropped until a byte arrives with pattern_start set
module tracker_pattern_unpacker_top #(
  parameter int MAX_CELLS = 8192
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [tpu_pkg::ByteW-1:0] stream_byte,
  input  logic                      pattern_start,
  input  logic [tpu_pkg::CntW-1:0]  cells_in_pattern,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [tpu_pkg::ByteW-1:0] note,
  output logic [tpu_pkg::ByteW-1:0] instrument,
  output logic [tpu_pkg::ByteW-1:0] volume_column,
  output logic [tpu_pkg::ByteW-1:0] effect_command,
  output logic [tpu_pkg::ByteW-1:0] effect_parameter,
  output logic                      last_cell
);
  import tpu_pkg::*;

  logic accept;
  logic push;
  op_t  push_op;
  logic push_ready;
  logic pop;
  logic head_valid;
  op_t  head_op;

  assign in_ready = push_ready;
  assign accept   = in_valid && in_ready;

  tpu_front #(
    .MAX_CELLS(MAX_CELLS)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .accept          (accept),
    .stream_byte     (stream_byte),
    .pattern_start   (pattern_start),
    .cells_in_pattern(cells_in_pattern),
    .push            (push),
    .op              (push_op)
  );

  tpu_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_op   (push_op),
    .push_ready(push_ready),
    .pop       (pop),
    .head_valid(head_valid),
    .head_op   (head_op)
  );

  tpu_back u_back (
    .clk             (clk),
    .rst             (rst),
    .head_valid      (head_valid),
    .head_op         (head_op),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .note            (note),
    .instrument      (instrument),
    .volume_column   (volume_column),
    .effect_command  (effect_command),
    .effect_parameter(effect_parameter),
    .last_cell       (last_cell)
  );

endmodule

// ===== rtl/core/tpu_checker.sv =====
module tpu_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] note,
  input logic [7:0] instrument,
  input logic [7:0] volume_column,
  input logic [7:0] effect_command,
  input logic [7:0] effect_parameter,
  input logic       last_cell
);
  import tpu_pkg::*;

  // reset empties the output stage
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high after reset");

  // an extended effect never leaves unmapped
  a_no_raw_ext: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (effect_command != ExtEffect))
    else $error("effect 0xE not remapped");

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("item dropped while stalled");

  a_payload_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> ($stable(note) && $stable(instrument)
      && $stable(volume_column) && $stable(effect_command)
      && $stable(effect_parameter) && $stable(last_cell)))
    else $error("payload changed while stalled");

endmodule

bind tracker_pattern_unpacker_top tpu_checker u_tpu_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .note            (note),
  .instrument      (instrument),
  .volume_column   (volume_column),
  .effect_command  (effect_command),
  .effect_parameter(effect_parameter),
  .last_cell       (last_cell)
);
